// File: rtl/tvlr_pkg.sv
// ----------------------------------------------------------------------------
// tvlr_pkg
// Shared types, codes and helpers of the tile video line renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tvlr_pkg;

    localparam int LINE_WIDTH    = 160;
    localparam int VISIBLE_LINES = 144;
    localparam int ADDR_W        = 13;

    // Item kinds
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_VRAM = 2'd1;
    localparam logic [1:0] ACT_OAM  = 2'd2;
    localparam logic [1:0] ACT_REG  = 2'd3;

    // Register numbers
    localparam logic [ADDR_W-1:0] REG_CTRL = 13'd0;
    localparam logic [ADDR_W-1:0] REG_STAT = 13'd1;
    localparam logic [ADDR_W-1:0] REG_SCY  = 13'd2;
    localparam logic [ADDR_W-1:0] REG_SCX  = 13'd3;
    localparam logic [ADDR_W-1:0] REG_LYC  = 13'd4;
    localparam logic [ADDR_W-1:0] REG_BGP  = 13'd5;
    localparam logic [ADDR_W-1:0] REG_OBP0 = 13'd6;
    localparam logic [ADDR_W-1:0] REG_OBP1 = 13'd7;
    localparam logic [ADDR_W-1:0] REG_WY   = 13'd8;
    localparam logic [ADDR_W-1:0] REG_WX   = 13'd9;

    // Display modes held in the low status bits
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // Mode lengths in dots
    localparam logic [9:0] DOTS_OAM    = 10'd80;
    localparam logic [9:0] DOTS_DRAW   = 10'd172;
    localparam logic [9:0] DOTS_HBLANK = 10'd204;
    localparam logic [9:0] DOTS_LINE   = 10'd456;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    typedef struct packed {
        logic [7:0] ctrl;
        logic [7:0] scy;
        logic [7:0] scx;
        logic [7:0] lyc;
        logic [7:0] bgp;
        logic [7:0] obp0;
        logic [7:0] obp1;
        logic [7:0] wy;
        logic [7:0] wx;
        logic [7:0] line;
        logic [6:0] status;
    } tvlr_regs_t;

    typedef struct packed {
        logic       render;
        logic [7:0] row;
        logic       vreq;
        logic       sreq;
        logic       done;
    } tvlr_step_t;

    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] ci);
        logic [1:0] s;
        case (ci)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tvlr_in_if.sv
// ----------------------------------------------------------------------------
// tvlr_in_if
// Request channel: ticks, memory writes and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvlr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  dot_count;
    logic [12:0] address;
    logic [7:0]  write_data;

    modport source (output valid, action, dot_count, address, write_data, input ready);
    modport sink   (input valid, action, dot_count, address, write_data, output ready);
endinterface

`default_nettype wire

// File: rtl/tvlr_out_if.sv
// ----------------------------------------------------------------------------
// tvlr_out_if
// Result channel: pixel chunks and timing status.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvlr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_row;
    logic [2:0]  chunk_index;
    logic [63:0] pixel_shades;
    logic        pixels_valid;
    logic        last;
    logic        vblank_request;
    logic        status_request;
    logic        frame_done;
    logic [7:0]  line_now;
    logic [6:0]  status_now;

    modport source (output valid, pixel_row, chunk_index, pixel_shades, pixels_valid, last,
                    vblank_request, status_request, frame_done, line_now, status_now,
                    input ready);
    modport sink   (input valid, pixel_row, chunk_index, pixel_shades, pixels_valid, last,
                    vblank_request, status_request, frame_done, line_now, status_now,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/tvlr_timing.sv
// ----------------------------------------------------------------------------
// tvlr_timing
// Dot and line counters, mode sequencing, interrupts and display registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tvlr_timing
    import tvlr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  dot_count,
    input  wire logic [12:0] address,
    input  wire logic [7:0]  write_data,
    output tvlr_regs_t       regs,
    output tvlr_step_t       step_info
);

    logic [9:0]  dot_reg, dot_next;
    tvlr_regs_t  regs_reg, regs_next;
    logic [10:0] dsum;
    logic [9:0]  dsat;

    assign dsum = {1'b0, dot_reg} + {3'b000, dot_count};
    assign dsat = dsum[10] ? 10'h3FF : dsum[9:0];

    // Apply one request to the timing state
    always_comb
    begin
        dot_next  = dot_reg;
        regs_next = regs_reg;
        step_info = '0;
        step_info.row = regs_reg.line;
        if (step)
        begin
            case (action)
                ACT_REG:
                begin
                    case (address)
                        REG_CTRL: regs_next.ctrl = write_data;
                        REG_STAT: regs_next.status = {write_data[6:3], regs_reg.status[2:0]};
                        REG_SCY:  regs_next.scy  = write_data;
                        REG_SCX:  regs_next.scx  = write_data;
                        REG_LYC:  regs_next.lyc  = write_data;
                        REG_BGP:  regs_next.bgp  = write_data;
                        REG_OBP0: regs_next.obp0 = write_data;
                        REG_OBP1: regs_next.obp1 = write_data;
                        REG_WY:   regs_next.wy   = write_data;
                        REG_WX:   regs_next.wx   = write_data;
                        default:  ;
                    endcase
                end
                ACT_TICK:
                begin
                    if (!regs_reg.ctrl[7])
                    begin
                        dot_next       = '0;
                        regs_next.line = '0;
                    end
                    else
                    begin
                        dot_next = dsat;
                        // Coincidence against the line at the start of the tick
                        regs_next.status[2] = (regs_reg.line == regs_reg.lyc);
                        if (regs_reg.line == regs_reg.lyc && regs_reg.status[6])
                            step_info.sreq = 1'b1;
                        case (regs_reg.status[1:0])
                            MODE_OAM:
                            begin
                                if (dsat >= DOTS_OAM)
                                begin
                                    dot_next = dsat - DOTS_OAM;
                                    regs_next.status[1:0] = MODE_DRAW;
                                end
                            end
                            MODE_DRAW:
                            begin
                                if (dsat >= DOTS_DRAW)
                                begin
                                    dot_next = dsat - DOTS_DRAW;
                                    step_info.render = (regs_reg.line < 8'(VISIBLE_LINES));
                                    regs_next.status[1:0] = MODE_HBLANK;
                                    if (regs_reg.status[3])
                                        step_info.sreq = 1'b1;
                                end
                            end
                            MODE_HBLANK:
                            begin
                                if (dsat >= DOTS_HBLANK)
                                begin
                                    dot_next = dsat - DOTS_HBLANK;
                                    regs_next.line = regs_reg.line + 8'd1;
                                    if (regs_next.line == 8'(VISIBLE_LINES))
                                    begin
                                        regs_next.status[1:0] = MODE_VBLANK;
                                        step_info.vreq = 1'b1;
                                        step_info.done = 1'b1;
                                        if (regs_reg.status[4])
                                            step_info.sreq = 1'b1;
                                    end
                                    else
                                    begin
                                        regs_next.status[1:0] = MODE_OAM;
                                        if (regs_reg.status[5])
                                            step_info.sreq = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                if (dsat >= DOTS_LINE)
                                begin
                                    dot_next = dsat - DOTS_LINE;
                                    regs_next.line = regs_reg.line + 8'd1;
                                    if (regs_next.line > LAST_LINE)
                                    begin
                                        regs_next.line = '0;
                                        regs_next.status[1:0] = MODE_OAM;
                                        if (regs_reg.status[5])
                                            step_info.sreq = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            regs_reg <= '0;
            regs_reg.status <= {5'd0, MODE_OAM};
        end
        else
        begin
            dot_reg  <= dot_next;
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

// File: rtl/tile_video_line_renderer_unit.sv
// ----------------------------------------------------------------------------
// tile_video_line_renderer_unit
// Tile video unit: dot timing, interrupts and a sequenced line renderer.
// ----------------------------------------------------------------------------
// After reset the unit sweeps video and sprite memory to zero and takes no
// request meanwhile. A memory write, register write or tick that does not
// start the line renderer then gives a single result, registered in the
// cycle after it is taken. A tick that ends drawing on a visible line starts
// the line renderer, which reads video memory through one read port one byte
// a cycle: a map entry and two tile bytes per background or window pixel,
// then two tile bytes per drawn sprite after the sprite slot scan. It then
// reads 32-pixel chunks out of the line buffer, five in all, each held until
// taken. No request is taken while a result is pending.
`default_nettype none

module tile_video_line_renderer_unit
    import tvlr_pkg::*;
#(
    parameter int SPRITE_SLOTS     = 40,
    parameter int SPRITES_PER_LINE = 10
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tvlr_in_if.sink     in_ch,
    tvlr_out_if.source  out_ch
);

    localparam int SLOT_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(SPRITES_PER_LINE + 1);

    typedef enum logic [16:0] {
        ST_CLEAR    = 17'h00001,
        ST_IDLE     = 17'h00002,
        ST_BG_MAP   = 17'h00004,
        ST_BG_LO    = 17'h00008,
        ST_BG_HI    = 17'h00010,
        ST_BG_PIX   = 17'h00020,
        ST_SP_Y     = 17'h00040,
        ST_SP_X     = 17'h00080,
        ST_SP_T     = 17'h00100,
        ST_SP_A     = 17'h00200,
        ST_SP_ATTR  = 17'h00400,
        ST_SP_LO    = 17'h00800,
        ST_SP_HI    = 17'h01000,
        ST_SP_PRD   = 17'h02000,
        ST_SP_PWR   = 17'h04000,
        ST_OUT_RD   = 17'h08000,
        ST_OUT_WAIT = 17'h10000
    } state_t;

    state_t              state_reg, state_next;
    logic [12:0]         clr_reg;
    logic [7:0]          x_reg, row_reg, lo_reg, hi_reg;
    logic [12:0]         tile_addr_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [7:0]          sy_reg, sxp_reg, tile_reg, attr_reg;
    logic [2:0]          px_reg, chunk_reg;
    logic [5:0]          gi_reg;
    logic [63:0]         shades_reg;
    logic                out_valid_reg, pv_reg, last_reg, vreq_reg, sreq_reg, done_reg;

    tvlr_regs_t          regs;
    tvlr_step_t          step_info;
    logic                fire_in, fire_out;

    // Memories
    logic [7:0]          vram [8192];
    logic [7:0]          oam  [LINE_WIDTH];
    logic [1:0]          lbuf [LINE_WIDTH];
    logic                vram_we, oam_we, lb_we;
    logic [12:0]         vram_waddr, vram_raddr;
    logic [7:0]          vram_wdata, vram_q;
    logic [7:0]          oam_waddr, oam_raddr, oam_wdata, oam_q;
    logic [7:0]          lb_waddr, lb_raddr;
    logic [1:0]          lb_wdata, lb_q;

    // Pixel source selection
    logic [8:0]          win_x9, col;
    logic                win_hit, bg_any, map_sel, tall, sp_hit, col_ok, last_slot;
    logic [7:0]          winx, wyo, sx, by, tx, ty, sy_cand, pal;
    logic [2:0]          px, py, sbit;
    logic [12:0]         map_addr, bg_tile_addr, sp_addr;
    logic [1:0]          bg_ci, sp_ci, blank;
    logic [3:0]          ry, ry_f;

    tvlr_timing u_timing (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (fire_in),
        .action     (in_ch.action),
        .dot_count  (in_ch.dot_count),
        .address    (in_ch.address),
        .write_data (in_ch.write_data),
        .regs       (regs),
        .step_info  (step_info)
    );

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign fire_in     = in_ch.valid && in_ch.ready;
    assign fire_out    = out_valid_reg && out_ch.ready;

    // Background and window address math for pixel x_reg
    assign win_x9  = {1'b0, x_reg} + 9'd7;
    assign win_hit = regs.ctrl[5] && (row_reg >= regs.wy) && (win_x9 >= {1'b0, regs.wx});
    assign winx    = 8'(win_x9 - {1'b0, regs.wx});
    assign wyo     = row_reg - regs.wy;
    assign sx      = x_reg + regs.scx;
    assign by      = row_reg + regs.scy;
    assign bg_any  = win_hit || regs.ctrl[0];
    assign map_sel = win_hit ? regs.ctrl[6] : regs.ctrl[3];
    assign tx      = win_hit ? winx : sx;
    assign ty      = win_hit ? wyo : by;
    assign px      = tx[2:0];
    assign py      = ty[2:0];
    assign map_addr     = {2'b11, map_sel, ty[7:3], tx[7:3]};
    assign bg_tile_addr = {!regs.ctrl[4] && !vram_q[7], vram_q, py, 1'b0};
    assign bg_ci        = {vram_q[~px], lo_reg[~px]};
    assign blank        = regs.bgp[1:0];

    // Sprite math
    assign tall    = regs.ctrl[2];
    assign sy_cand = oam_q - 8'd16;
    assign sp_hit  = (row_reg >= sy_cand) &&
                     ({1'b0, row_reg} < ({1'b0, sy_cand} + (tall ? 9'd16 : 9'd8)));
    assign ry      = 4'(row_reg - sy_reg);
    assign ry_f    = !oam_q[6] ? ry : (tall ? ~ry : {1'b0, ~ry[2:0]});
    assign sp_addr = {1'b0, tile_reg[7:1], (tile_reg[0] && !tall) || ry_f[3], ry_f[2:0], 1'b0};
    assign col     = {1'b0, sxp_reg} + {6'd0, px_reg};
    assign col_ok  = col < 9'(LINE_WIDTH);
    assign sbit    = attr_reg[5] ? px_reg : ~px_reg;
    assign sp_ci   = {hi_reg[sbit], lo_reg[sbit]};
    assign pal     = attr_reg[4] ? regs.obp1 : regs.obp0;
    assign last_slot = (slot_reg == SLOT_W'(SPRITE_SLOTS - 1));

    // Memory port control
    always_comb
    begin
        vram_we    = 1'b0;
        vram_waddr = in_ch.address;
        vram_wdata = in_ch.write_data;
        oam_we     = 1'b0;
        oam_waddr  = in_ch.address[7:0];
        oam_wdata  = in_ch.write_data;
        if (state_reg == ST_CLEAR)
        begin
            vram_we    = 1'b1;
            vram_waddr = clr_reg;
            vram_wdata = '0;
            oam_we     = (clr_reg < 13'(LINE_WIDTH));
            oam_waddr  = clr_reg[7:0];
            oam_wdata  = '0;
        end
        else if (fire_in)
        begin
            vram_we = (in_ch.action == ACT_VRAM);
            oam_we  = (in_ch.action == ACT_OAM) && (in_ch.address < 13'(LINE_WIDTH));
        end

        case (state_reg)
            ST_BG_MAP: vram_raddr = map_addr;
            ST_BG_LO:  vram_raddr = bg_tile_addr;
            ST_BG_HI:  vram_raddr = {tile_addr_reg[12:1], 1'b1};
            ST_SP_ATTR: vram_raddr = sp_addr;
            ST_SP_LO:  vram_raddr = {tile_addr_reg[12:1], 1'b1};
            default:   vram_raddr = '0;
        endcase

        case (state_reg)
            ST_SP_Y: oam_raddr = 8'({slot_reg, 2'd0});
            ST_SP_X: oam_raddr = 8'({slot_reg, 2'd1});
            ST_SP_T: oam_raddr = 8'({slot_reg, 2'd2});
            ST_SP_A: oam_raddr = 8'({slot_reg, 2'd3});
            default: oam_raddr = '0;
        endcase

        lb_we    = 1'b0;
        lb_waddr = x_reg;
        lb_wdata = blank;
        case (state_reg)
            ST_BG_MAP: lb_we = !bg_any;
            ST_BG_PIX:
            begin
                lb_we    = 1'b1;
                lb_wdata = shade_of(regs.bgp, bg_ci);
            end
            ST_SP_PWR:
            begin
                lb_we    = !attr_reg[7] || (lb_q == blank);
                lb_waddr = col[7:0];
                lb_wdata = shade_of(pal, sp_ci);
            end
            default: ;
        endcase

        case (state_reg)
            ST_SP_PRD: lb_raddr = col[7:0];
            ST_OUT_RD: lb_raddr = {chunk_reg, gi_reg[4:0]};
            default:   lb_raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram[vram_waddr] <= vram_wdata;
        vram_q <= vram[vram_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
            oam[oam_waddr] <= oam_wdata;
        oam_q <= oam[oam_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lb_we)
            lbuf[lb_waddr] <= lb_wdata;
        lb_q <= lbuf[lb_raddr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == 13'h1FFF)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (fire_in && step_info.render)
                    state_next = ST_BG_MAP;
            ST_BG_MAP, ST_BG_PIX:
            begin
                if (state_reg == ST_BG_MAP && bg_any)
                    state_next = ST_BG_LO;
                else if (x_reg == 8'(LINE_WIDTH - 1))
                    state_next = regs.ctrl[1] ? ST_SP_Y : ST_OUT_RD;
                else
                    state_next = ST_BG_MAP;
            end
            ST_BG_LO: state_next = ST_BG_HI;
            ST_BG_HI: state_next = ST_BG_PIX;
            ST_SP_Y:  state_next = ST_SP_X;
            ST_SP_X:
            begin
                if (sp_hit)
                    state_next = ST_SP_T;
                else
                    state_next = last_slot ? ST_OUT_RD : ST_SP_Y;
            end
            ST_SP_T:    state_next = ST_SP_A;
            ST_SP_A:    state_next = ST_SP_ATTR;
            ST_SP_ATTR: state_next = ST_SP_LO;
            ST_SP_LO:   state_next = ST_SP_HI;
            ST_SP_HI:   state_next = ST_SP_PRD;
            ST_SP_PRD, ST_SP_PWR:
            begin
                if (state_reg == ST_SP_PRD && col_ok && sp_ci != 2'd0)
                    state_next = ST_SP_PWR;
                else if (px_reg != 3'd7)
                    state_next = ST_SP_PRD;
                else if (last_slot || cnt_reg == CNT_W'(SPRITES_PER_LINE))
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_SP_Y;
            end
            ST_OUT_RD:
                if (gi_reg == 6'd32)
                    state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                if (fire_out)
                    state_next = (chunk_reg == 3'd4) ? ST_IDLE : ST_OUT_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            px_reg        <= '0;
            chunk_reg     <= '0;
            gi_reg        <= '0;
            pv_reg        <= 1'b0;
            last_reg      <= 1'b0;
            vreq_reg      <= 1'b0;
            sreq_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire_out)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 13'd1;
                ST_IDLE:
                begin
                    if (fire_in)
                    begin
                        vreq_reg  <= step_info.vreq;
                        sreq_reg  <= step_info.sreq;
                        done_reg  <= step_info.done;
                        chunk_reg <= '0;
                        x_reg     <= '0;
                        if (step_info.render)
                            row_reg <= step_info.row;
                        else
                        begin
                            row_reg       <= '0;
                            shades_reg    <= '0;
                            pv_reg        <= 1'b0;
                            last_reg      <= 1'b1;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_BG_MAP, ST_BG_PIX:
                begin
                    if (!(state_reg == ST_BG_MAP && bg_any))
                    begin
                        x_reg    <= x_reg + 8'd1;
                        slot_reg <= '0;
                        cnt_reg  <= '0;
                        gi_reg   <= '0;
                    end
                end
                ST_BG_LO: tile_addr_reg <= bg_tile_addr;
                ST_BG_HI: lo_reg <= vram_q;
                ST_SP_X:
                begin
                    if (sp_hit)
                    begin
                        sy_reg  <= sy_cand;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else
                        slot_reg <= slot_reg + SLOT_W'(1);
                end
                ST_SP_T:    sxp_reg <= oam_q - 8'd8;
                ST_SP_A:    tile_reg <= oam_q;
                ST_SP_ATTR:
                begin
                    attr_reg      <= oam_q;
                    tile_addr_reg <= sp_addr;
                end
                ST_SP_LO: lo_reg <= vram_q;
                ST_SP_HI:
                begin
                    hi_reg <= vram_q;
                    px_reg <= '0;
                end
                ST_SP_PRD, ST_SP_PWR:
                begin
                    if (!(state_reg == ST_SP_PRD && col_ok && sp_ci != 2'd0))
                    begin
                        px_reg <= px_reg + 3'd1;
                        if (px_reg == 3'd7)
                            slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                ST_OUT_RD:
                begin
                    // Shift pixels in so pixel 0 lands in the low bits
                    if (gi_reg != 6'd0)
                        shades_reg <= {lb_q, shades_reg[63:2]};
                    if (gi_reg == 6'd32)
                    begin
                        out_valid_reg <= 1'b1;
                        pv_reg        <= 1'b1;
                        last_reg      <= (chunk_reg == 3'd4);
                    end
                    else
                        gi_reg <= gi_reg + 6'd1;
                end
                ST_OUT_WAIT:
                begin
                    if (fire_out && chunk_reg != 3'd4)
                    begin
                        chunk_reg <= chunk_reg + 3'd1;
                        gi_reg    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pixel_row      = row_reg;
    assign out_ch.chunk_index    = chunk_reg;
    assign out_ch.pixel_shades   = shades_reg;
    assign out_ch.pixels_valid   = pv_reg;
    assign out_ch.last           = last_reg;
    assign out_ch.vblank_request = vreq_reg;
    assign out_ch.status_request = sreq_reg;
    assign out_ch.frame_done     = done_reg;
    assign out_ch.line_now       = regs.line;
    assign out_ch.status_now     = regs.status;

    // Checks
    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("request taken while a result is pending");

    a_plain_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.pixels_valid |-> out_ch.last)
        else $error("result without pixels not marked last");

    a_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.pixels_valid |->
            out_ch.chunk_index <= 3'd4 && out_ch.pixel_row < 8'(VISIBLE_LINES))
        else $error("pixel chunk out of range");

    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire_out && out_ch.last |=> !out_ch.valid)
        else $error("result shown right after the last one");

endmodule

`default_nettype wire

// File: tb/sv/tb_tile_video_line_renderer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tile_video_line_renderer_unit
// Self-checking bench for the tile video line renderer. A queue of requests
// (ticks, video and sprite memory writes, register writes) feeds a clocked
// driver. A line predictor inside the bench computes the expected results of
// every accepted request, and a clocked monitor checks each result, field by
// field, against the oldest expectation. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_tile_video_line_renderer_unit;
    import tvlr_pkg::*;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  dots;
        logic [12:0] address;
        logic [7:0]  data;
    } video_request_t;

    typedef struct {
        logic [7:0]  row;
        logic [2:0]  chunk;
        logic [63:0] shades;
        logic        pix_valid;
        logic        last;
        logic        vblank_req;
        logic        status_req;
        logic        frame_end;
        logic [7:0]  line;
        logic [6:0]  status;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tvlr_in_if  in_ch ();
    tvlr_out_if out_ch ();

    tile_video_line_renderer_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    // Predicted display state
    logic [7:0] vram_img [8192];
    logic [7:0] oam_img  [160];
    logic [1:0] row_shades [160];
    logic [7:0] disp_regs [9];
    int         dot_acc;
    int         cur_line;
    logic [6:0] stat_img;

    video_request_t request_queue [$];
    line_result_t   expected_results [$];

    int accepted_requests = 0;
    int checked_results   = 0;
    int mismatches        = 0;
    int rendered_lines    = 0;
    int frames_seen       = 0;
    int status_irqs       = 0;
    bit hold_go           = 1'b0;

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------
    function automatic logic [1:0] pal_shade(logic [7:0] pal, int idx);
        return pal[(idx & 3) * 2 +: 2];
    endfunction

    function automatic int tile_color_index(int addr, int bitpos);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = vram_img[addr & 16'h1FFF];
        hi = vram_img[(addr + 1) & 16'h1FFF];
        return {hi[bitpos & 7], lo[bitpos & 7]};
    endfunction

    function automatic int map_color_index(int map, int tx, int ty, int px, int py);
        int id;
        int base;
        id = vram_img[(map + (ty & 31) * 32 + (tx & 31)) & 16'h1FFF];
        base = (!disp_regs[0][4] && id < 'h80) ? 'h1000 + id * 16 : id * 16;
        return tile_color_index(base + (py & 7) * 2, 7 - (px & 7));
    endfunction

    task automatic render_row(int ly);
        logic [7:0] ctrl;
        logic [1:0] blank;
        logic [7:0] attr;
        logic [7:0] pal;
        int map, y, sx, wyo, start, winx, height, count, spy, spx, tile, ry, addr, col, ci;
        ctrl  = disp_regs[0];
        blank = pal_shade(disp_regs[4], 0);
        for (int x = 0; x < LINE_WIDTH; x++)
            row_shades[x] = blank;
        // background with scroll
        if (ctrl[0])
        begin
            map = ctrl[3] ? 'h1C00 : 'h1800;
            y   = (ly + disp_regs[1]) & 'hFF;
            for (int x = 0; x < LINE_WIDTH; x++)
            begin
                sx = (x + disp_regs[2]) & 'hFF;
                row_shades[x] = pal_shade(disp_regs[4],
                    map_color_index(map, sx >> 3, y >> 3, sx & 7, y & 7));
            end
        end
        // window, drawn even with background off
        if (ctrl[5] && ly >= disp_regs[7])
        begin
            map   = ctrl[6] ? 'h1C00 : 'h1800;
            wyo   = ly - disp_regs[7];
            start = (disp_regs[8] < 7) ? 0 : disp_regs[8] - 7;
            for (int x = start; x < LINE_WIDTH; x++)
            begin
                winx = x + 7 - disp_regs[8];
                row_shades[x] = pal_shade(disp_regs[4],
                    map_color_index(map, winx >> 3, wyo >> 3, winx & 7, wyo & 7));
            end
        end
        // sprites in table order, later ones overwrite
        if (ctrl[1])
        begin
            height = ctrl[2] ? 16 : 8;
            count  = 0;
            for (int s = 0; s < 40 && count < 10; s++)
            begin
                spy  = (oam_img[s * 4] - 16) & 'hFF;
                spx  = (oam_img[s * 4 + 1] - 8) & 'hFF;
                tile = oam_img[s * 4 + 2];
                attr = oam_img[s * 4 + 3];
                if (ly < spy || ly >= spy + height)
                    continue;
                count++;
                ry = ly - spy;
                if (attr[6])
                    ry = height - 1 - ry;
                if (height == 16)
                    tile = tile & 'hFE;
                addr = tile * 16 + ry * 2;
                pal  = attr[4] ? disp_regs[6] : disp_regs[5];
                for (int x = 0; x < 8; x++)
                begin
                    col = spx + x;
                    if (col >= LINE_WIDTH)
                        continue;
                    ci = tile_color_index(addr, attr[5] ? x : 7 - x);
                    if (ci == 0)
                        continue;
                    if (attr[7] && row_shades[col] != blank)
                        continue;
                    row_shades[col] = pal_shade(pal, ci);
                end
            end
        end
    endtask

    task automatic predict_request(video_request_t rq);
        line_result_t r;
        bit vreq, sreq, done, drawn;
        int row;
        vreq = 0; sreq = 0; done = 0; drawn = 0; row = 0;
        case (rq.action)
            ACT_VRAM: vram_img[rq.address] = rq.data;
            ACT_OAM:
                if (rq.address < 160)
                    oam_img[rq.address] = rq.data;
            ACT_REG:
                if (rq.address == REG_CTRL)
                    disp_regs[0] = rq.data;
                else if (rq.address == REG_STAT)
                    stat_img = {rq.data[6:3], stat_img[2:0]};
                else if (rq.address <= REG_WX)
                    disp_regs[rq.address - 1] = rq.data;
            default:
                if (!disp_regs[0][7])
                begin
                    cur_line = 0;
                    dot_acc  = 0;
                end
                else
                begin
                    dot_acc = dot_acc + rq.dots;
                    if (dot_acc > 1023)
                        dot_acc = 1023;
                    // coincidence against the line at tick start
                    if (cur_line == disp_regs[3])
                    begin
                        stat_img[2] = 1'b1;
                        if (stat_img[6])
                            sreq = 1;
                    end
                    else
                        stat_img[2] = 1'b0;
                    case (stat_img[1:0])
                        MODE_OAM:
                            if (dot_acc >= DOTS_OAM)
                            begin
                                dot_acc -= DOTS_OAM;
                                stat_img[1:0] = MODE_DRAW;
                            end
                        MODE_DRAW:
                            if (dot_acc >= DOTS_DRAW)
                            begin
                                dot_acc -= DOTS_DRAW;
                                if (cur_line < VISIBLE_LINES)
                                begin
                                    render_row(cur_line);
                                    drawn = 1;
                                    row   = cur_line;
                                end
                                stat_img[1:0] = MODE_HBLANK;
                                if (stat_img[3])
                                    sreq = 1;
                            end
                        MODE_HBLANK:
                            if (dot_acc >= DOTS_HBLANK)
                            begin
                                dot_acc -= DOTS_HBLANK;
                                cur_line = (cur_line + 1) & 'hFF;
                                if (cur_line == VISIBLE_LINES)
                                begin
                                    stat_img[1:0] = MODE_VBLANK;
                                    vreq = 1;
                                    done = 1;
                                    if (stat_img[4])
                                        sreq = 1;
                                end
                                else
                                begin
                                    stat_img[1:0] = MODE_OAM;
                                    if (stat_img[5])
                                        sreq = 1;
                                end
                            end
                        default:
                            if (dot_acc >= DOTS_LINE)
                            begin
                                dot_acc -= DOTS_LINE;
                                cur_line = (cur_line + 1) & 'hFF;
                                if (cur_line > LAST_LINE)
                                begin
                                    cur_line = 0;
                                    stat_img[1:0] = MODE_OAM;
                                    if (stat_img[5])
                                        sreq = 1;
                                end
                            end
                    endcase
                end
        endcase
        rendered_lines += drawn;
        frames_seen    += done;
        status_irqs    += sreq;
        for (int k = 0; k < (drawn ? 5 : 1); k++)
        begin
            r.row       = drawn ? row[7:0] : 8'd0;
            r.chunk     = drawn ? k[2:0] : 3'd0;
            r.shades    = '0;
            if (drawn)
                for (int i = 0; i < 32; i++)
                    r.shades[2 * i +: 2] = row_shades[k * 32 + i];
            r.pix_valid  = drawn;
            r.last       = (k == (drawn ? 4 : 0));
            r.vblank_req = vreq;
            r.status_req = sreq;
            r.frame_end  = done;
            r.line       = cur_line[7:0];
            r.status     = stat_img;
            expected_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one request from the queue at a time, random gaps
    // ------------------------------------------------------------------
    video_request_t cur_rq;
    int  send_gap  = 0;
    bit  send_rush = 0;

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_TICK;
        in_ch.dot_count  = '0;
        in_ch.address    = '0;
        in_ch.write_data = '0;
        out_ch.ready     = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            // record the accepted request and draw the next gap
            if (in_ch.valid && in_ch.ready)
            begin
                predict_request(cur_rq);
                accepted_requests++;
                if ($urandom_range(0, 29) == 0)
                    send_rush = !send_rush;
                send_gap = send_rush ? 0 : $urandom_range(0, 13);
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    cur_rq = request_queue.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.action     <= cur_rq.action;
                    in_ch.dot_count  <= cur_rq.dots;
                    in_ch.address    <= cur_rq.address;
                    in_ch.write_data <= cur_rq.data;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stalls, one long hold-off, compare with predictions
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_used  = 0;
    bit recv_rush  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t exp_r;
        line_result_t got;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.row        = out_ch.pixel_row;
                got.chunk      = out_ch.chunk_index;
                got.shades     = out_ch.pixel_shades;
                got.pix_valid  = out_ch.pixels_valid;
                got.last       = out_ch.last;
                got.vblank_req = out_ch.vblank_request;
                got.status_req = out_ch.status_request;
                got.frame_end  = out_ch.frame_done;
                got.line       = out_ch.line_now;
                got.status     = out_ch.status_now;
                checked_results++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result row=%0d chunk=%0d line=%0d",
                                 got.row, got.chunk, got.line);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.row !== exp_r.row || got.chunk !== exp_r.chunk ||
                        got.shades !== exp_r.shades || got.pix_valid !== exp_r.pix_valid ||
                        got.last !== exp_r.last || got.vblank_req !== exp_r.vblank_req ||
                        got.status_req !== exp_r.status_req ||
                        got.frame_end !== exp_r.frame_end ||
                        got.line !== exp_r.line || got.status !== exp_r.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR: result %0d mismatch", checked_results);
                            $display("  exp row=%0d chunk=%0d pix=%h pv=%b last=%b v=%b s=%b fd=%b ly=%0d st=%h",
                                     exp_r.row, exp_r.chunk, exp_r.shades, exp_r.pix_valid,
                                     exp_r.last, exp_r.vblank_req, exp_r.status_req,
                                     exp_r.frame_end, exp_r.line, exp_r.status);
                            $display("  got row=%0d chunk=%0d pix=%h pv=%b last=%b v=%b s=%b fd=%b ly=%0d st=%h",
                                     got.row, got.chunk, got.shades, got.pix_valid,
                                     got.last, got.vblank_req, got.status_req,
                                     got.frame_end, got.line, got.status);
                        end
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    recv_rush = !recv_rush;
                stall_left = recv_rush ? 0 : $urandom_range(0, 13);
            end
            else if (stall_left > 0)
                stall_left--;
            // long hold-off so the block backs up into its input
            if (hold_go && !hold_used)
            begin
                hold_used = 1;
                hold_left = 600;
            end
            else if (hold_left > 0)
                hold_left--;
            out_ch.ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_request(logic [1:0] act, logic [7:0] dots, logic [12:0] addr,
                               logic [7:0] data);
        video_request_t rq;
        rq.action = act; rq.dots = dots; rq.address = addr; rq.data = data;
        request_queue.push_back(rq);
    endtask

    task automatic wait_drained();
        while (request_queue.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic add_random_request();
        int pick;
        logic [12:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            add_request(ACT_TICK, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(60, 255),
                        $urandom_range(0, 8191), $urandom_range(0, 255));
        else if (pick < 75)
        begin
            a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                            : $urandom_range('h1800, 'h1BFF);
            if ($urandom_range(0, 1) == 0)
                a = $urandom_range(0, 'h3F);
            add_request(ACT_VRAM, $urandom_range(0, 255), a, $urandom_range(0, 255));
        end
        else if (pick < 87)
        begin
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 159);
            d = $urandom_range(0, 255);
            // keep sprite Y mostly near the lines reached
            if (a % 4 == 0 && $urandom_range(0, 3) != 0)
                d = $urandom_range(10, 60);
            add_request(ACT_OAM, $urandom_range(0, 255), a, d);
        end
        else
        begin
            a = $urandom_range(0, 15);
            d = $urandom_range(0, 255);
            if (a == REG_CTRL && $urandom_range(0, 9) != 0)
                d[7] = 1'b1;
            if (a == REG_LYC && $urandom_range(0, 1) == 0)
                d = $urandom_range(0, 40);
            add_request(ACT_REG, $urandom_range(0, 255), a, d);
        end
    endtask

    initial
    begin
        int start_count;
        for (int i = 0; i < 8192; i++)
            vram_img[i] = '0;
        for (int i = 0; i < 160; i++)
        begin
            oam_img[i]    = '0;
            row_shades[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            disp_regs[i] = '0;
        dot_acc  = 0;
        cur_line = 0;
        stat_img = {5'd0, MODE_OAM};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: display off tick, setup, extremes, both sprite flips
        add_request(ACT_TICK, 8'd255, 13'd0, 8'd0);
        add_request(ACT_REG, 8'd0, REG_STAT, 8'hFF);
        add_request(ACT_REG, 8'd0, REG_BGP, 8'hE4);
        add_request(ACT_REG, 8'd0, REG_OBP0, 8'hD2);
        add_request(ACT_REG, 8'd0, REG_OBP1, 8'h1B);
        add_request(ACT_REG, 8'd0, REG_SCX, 8'hFF);
        add_request(ACT_REG, 8'd0, REG_SCY, 8'h03);
        add_request(ACT_REG, 8'd0, REG_WY, 8'd0);
        add_request(ACT_REG, 8'd0, REG_WX, 8'd3);
        add_request(ACT_REG, 8'd0, 13'd12, 8'hAA);
        add_request(ACT_VRAM, 8'd0, 13'h0010, 8'hF0);
        add_request(ACT_VRAM, 8'd0, 13'h0011, 8'h3C);
        add_request(ACT_VRAM, 8'd0, 13'h1FFF, 8'hFF);
        add_request(ACT_VRAM, 8'd0, 13'h1800, 8'h81);
        add_request(ACT_OAM, 8'd0, 13'd0, 8'd16);
        add_request(ACT_OAM, 8'd0, 13'd1, 8'd4);
        add_request(ACT_OAM, 8'd0, 13'd2, 8'd1);
        add_request(ACT_OAM, 8'd0, 13'd3, 8'hF0);
        add_request(ACT_OAM, 8'd0, 13'd200, 8'd16);
        add_request(ACT_REG, 8'd0, REG_CTRL, 8'hE3);
        add_request(ACT_REG, 8'd0, REG_LYC, 8'd0);
        add_request(ACT_TICK, 8'd255, 13'd0, 8'd0);
        add_request(ACT_TICK, 8'd255, 13'd0, 8'd0);
        add_request(ACT_TICK, 8'd255, 13'd0, 8'd0);
        add_request(ACT_TICK, 8'd0, 13'd0, 8'd0);
        wait_drained();

        // random traffic with one long receiver hold-off
        start_count = accepted_requests;
        for (int i = 0; i < 330; i++)
            add_random_request();
        while (accepted_requests < start_count + 60)
            @(posedge clk);
        hold_go <= 1'b1;
        wait_drained();

        // full frame sweep to reach vblank and wrap around
        add_request(ACT_REG, 8'd0, REG_CTRL, 8'hB7);
        add_request(ACT_REG, 8'd0, REG_LYC, 8'd150);
        for (int i = 0; i < 470; i++)
            add_request(ACT_TICK, $urandom_range(200, 255), $urandom_range(0, 8191),
                        $urandom_range(0, 255));
        add_request(ACT_REG, 8'd0, REG_CTRL, 8'h00);
        add_request(ACT_TICK, 8'd17, 13'd0, 8'd0);
        wait_drained();
        repeat (50) @(posedge clk);

        $display("Run covered %0d requests, %0d results, %0d rendered lines,",
                 accepted_requests, checked_results, rendered_lines);
        $display("%0d frames finished, %0d status requests, %0d mismatches.",
                 frames_seen, status_irqs, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #8ms;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/tvlr_pkg.sv
rtl/tvlr_in_if.sv
rtl/tvlr_out_if.sv
rtl/tvlr_timing.sv
rtl/tile_video_line_renderer_unit.sv
tb/sv/tb_tile_video_line_renderer_unit.sv
